// ----- rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, codes and constants of the sprite frame and fade animator:
// request and response payloads, channel settings layout, controller codes.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int NUM_CHAN = 4;
   localparam int CHAN_W   = $clog2(NUM_CHAN);

   // shared divider sizes
   localparam int DVD_W = 25;   // dividend / quotient width
   localparam int DSR_W = 17;   // divisor / remainder width
   localparam int CNT_W = $clog2(DVD_W);

   localparam logic [6:0]  FULL_PERCENT = 7'd100;
   localparam logic [55:0] SETTINGS_RESET = 56'h0080_00E4_C800_0201;

   // request op codes
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   // draw mode codes
   localparam logic [1:0] DRAW_HIDDEN      = 2'd0;
   localparam logic [1:0] DRAW_TRANSLUCENT = 2'd1;
   localparam logic [1:0] DRAW_OPAQUE      = 2'd2;

   typedef struct packed {
      logic        op;
      logic [15:0] elapsed;
      logic [1:0]  channel;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_index;
      logic [6:0] alpha_percent;
      logic [1:0] draw_mode;
   } rsp_type;

   // per channel settings, msb first
   typedef struct packed {
      logic        mirror;
      logic [15:0] fade;
      logic [6:0]  end_pct;
      logic [6:0]  start_pct;
      logic [15:0] period;
      logic        pingpong;
      logic [7:0]  frames;
   } settings_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_A_TICK,
      ST_A_TICK_WAIT,
      ST_A_POS,
      ST_A_POS_WAIT,
      ST_A_POS_WR,
      ST_A_FADE,
      ST_A_FADE_WAIT,
      ST_A_FADE_WR,
      ST_Q_MUL,
      ST_Q_DIV,
      ST_Q_WAIT,
      ST_Q_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_TICK,
      DIV_POS,
      DIV_FADE,
      DIV_ALPHA
   } div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic              accept;
      logic              div_start;
      div_sel_type       div_sel;
      logic              wr_tick;
      logic              wr_pos;
      logic              wr_fade;
      logic              mul_load;
      logic              rsp_load;
      logic [CHAN_W-1:0] chan;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic steps_nz;
      logic is_query;
   } status_type;

endpackage

// ----- rtl/sfa_div.sv -----
// ----------------------------------------------------------------------------
// sfa_div
// Shared unsigned restoring divider, one quotient bit per cycle. Quotient and
// remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module sfa_div
   import sfa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quot,
   output logic [DSR_W-1:0] rem
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   shifted;
   logic [DSR_W:0]   trial;
   logic             fits;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quot_ff[DVD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
   end

   // iteration control and data
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (run_ff) begin
         quot_in = {quot_ff[DVD_W-2:0], fits};
         rem_in  = fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/sfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfa_ctrl
// Controller: accepts requests, sequences the shared divider over the four
// channels on an advance, and through multiply, divide and output on a query.
// ----------------------------------------------------------------------------
module sfa_ctrl
   import sfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output cmd_type    cmd,
   input  status_type status
);

   ctrl_state_type    state_ff, state_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic              last_chan;

   assign last_chan = (chan_ff == CHAN_W'(NUM_CHAN - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            chan_in  = '0;
            state_in = status.is_query ? ST_Q_MUL : ST_A_TICK;
         end
         ST_A_TICK:      state_in = ST_A_TICK_WAIT;
         ST_A_TICK_WAIT: begin
            if (status.div_done) state_in = ST_A_POS;
         end
         ST_A_POS:       state_in = status.steps_nz ? ST_A_POS_WAIT : ST_A_FADE;
         ST_A_POS_WAIT: begin
            if (status.div_done) state_in = ST_A_POS_WR;
         end
         ST_A_POS_WR:    state_in = ST_A_FADE;
         ST_A_FADE:      state_in = ST_A_FADE_WAIT;
         ST_A_FADE_WAIT: begin
            if (status.div_done) state_in = ST_A_FADE_WR;
         end
         ST_A_FADE_WR: begin
            if (last_chan) begin
               state_in = ST_IDLE;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_A_TICK;
            end
         end
         ST_Q_MUL:       state_in = ST_Q_DIV;
         ST_Q_DIV:       state_in = ST_Q_WAIT;
         ST_Q_WAIT: begin
            if (status.div_done) state_in = ST_Q_OUT;
         end
         ST_Q_OUT:       state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_TICK;
      cmd.chan    = chan_ff;
      busy        = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:      cmd.accept = start;
         ST_A_TICK: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TICK;
         end
         ST_A_POS: begin
            cmd.wr_tick   = 1'b1;
            cmd.div_start = status.steps_nz;
            cmd.div_sel   = DIV_POS;
         end
         ST_A_POS_WR:  cmd.wr_pos = 1'b1;
         ST_A_FADE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FADE;
         end
         ST_A_FADE_WR: cmd.wr_fade = 1'b1;
         ST_Q_MUL:     cmd.mul_load = 1'b1;
         ST_Q_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ALPHA;
         end
         ST_Q_OUT:     cmd.rsp_load = 1'b1;
         default:      cmd.accept = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

// ----- rtl/sfa_dpath.sv -----
// ----------------------------------------------------------------------------
// sfa_dpath
// Datapath: per channel tick, frame and fade state, the shared divider and
// its operand selection, the alpha multiplier and the response register.
// ----------------------------------------------------------------------------
module sfa_dpath
   import sfa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  req_type                     req_data,
   input  settings_type [NUM_CHAN-1:0] settings,
   input  cmd_type                     cmd,
   output status_type                  status,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data
);

   req_type     req_ff;
   logic [15:0] acc_ff  [NUM_CHAN];
   logic [8:0]  pos_ff  [NUM_CHAN];
   logic [16:0] fade_ff [NUM_CHAN];
   logic [23:0] prod_mag_ff, prod_mag_in;
   logic        prod_neg_ff, prod_neg_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_strobe_ff;

   logic [CHAN_W-1:0] idx;
   settings_type      cur;
   logic [15:0]       acc_cur;
   logic [8:0]        pos_cur;
   logic [16:0]       fade_cur;
   logic [7:0]        frames_eff;
   logic [15:0]       period_eff;
   logic [15:0]       fade_eff;
   logic [8:0]        cyc;
   logic [16:0]       fade_wrap;

   logic             div_start;
   logic [DVD_W-1:0] dvd;
   logic [DSR_W-1:0] dsr;
   logic             div_done;
   logic [DVD_W-1:0] quot;
   logic [DSR_W-1:0] rem;

   logic signed [7:0]  diff;
   logic signed [18:0] cfold;
   logic signed [26:0] prod;
   logic signed [25:0] qsgn;
   logic signed [25:0] ps;
   logic [8:0]         shown;

   // selected channel and effective settings
   always_comb begin
      idx        = (req_ff.op == OP_QUERY) ? req_ff.channel : cmd.chan;
      cur        = settings[idx];
      acc_cur    = acc_ff[idx];
      pos_cur    = pos_ff[idx];
      fade_cur   = fade_ff[idx];
      frames_eff = (cur.frames == '0) ? 8'd1 : cur.frames;
      period_eff = (cur.period == '0) ? 16'd1 : cur.period;
      fade_eff   = (cur.fade == '0) ? 16'd1 : cur.fade;
      if (!cur.pingpong)      cyc = {1'b0, frames_eff};
      else if (frames_eff > 8'd1) cyc = {frames_eff, 1'b0} - 9'd2;
      else                    cyc = 9'd1;
      fade_wrap  = cur.mirror ? {fade_eff, 1'b0} : {1'b0, fade_eff};
   end

   // divider operand selection
   always_comb begin
      case (cmd.div_sel)
         DIV_TICK: begin
            dvd = DVD_W'({1'b0, acc_cur} + {1'b0, req_ff.elapsed});
            dsr = {1'b0, period_eff};
         end
         DIV_POS: begin
            dvd = DVD_W'({9'b0, pos_cur} + {1'b0, quot[16:0]});
            dsr = DSR_W'(cyc);
         end
         DIV_FADE: begin
            dvd = DVD_W'({1'b0, fade_cur} + 18'd1);
            dsr = fade_wrap;
         end
         DIV_ALPHA: begin
            dvd = {1'b0, prod_mag_ff};
            dsr = {1'b0, fade_eff};
         end
         default: begin
            dvd = '0;
            dsr = DSR_W'(1);
         end
      endcase
   end

   assign div_start = cmd.div_start;

   sfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   assign status.div_done = div_done;
   assign status.steps_nz = (quot != '0);
   assign status.is_query = (req_ff.op == OP_QUERY);

   // alpha slope times folded fade counter
   always_comb begin
      diff = $signed({1'b0, cur.end_pct}) - $signed({1'b0, cur.start_pct});
      if (cur.mirror && (fade_cur >= {1'b0, fade_eff}))
         cfold = $signed({2'b0, fade_eff, 1'b0}) - $signed({2'b0, fade_cur});
      else
         cfold = $signed({2'b0, fade_cur});
      prod        = diff * cfold;
      prod_neg_in = prod[26];
      prod_mag_in = prod[26] ? 24'(-prod) : prod[23:0];
   end

   // response: folded frame, clamped alpha, draw mode
   always_comb begin
      shown = pos_cur;
      if (cur.pingpong && (pos_cur >= {1'b0, frames_eff}))
         shown = (pos_cur <= cyc) ? (cyc - pos_cur) : 9'd0;
      qsgn = prod_neg_ff ? -$signed({2'b0, quot[23:0]}) : $signed({2'b0, quot[23:0]});
      ps   = $signed({19'b0, cur.start_pct}) + qsgn;
      rsp_in.frame_index = shown[7:0];
      if (ps[25])                      rsp_in.alpha_percent = 7'd0;
      else if (ps > 26'sd100)          rsp_in.alpha_percent = FULL_PERCENT;
      else                             rsp_in.alpha_percent = ps[6:0];
      if (rsp_in.alpha_percent == FULL_PERCENT) rsp_in.draw_mode = DRAW_OPAQUE;
      else if (rsp_in.alpha_percent != 7'd0)    rsp_in.draw_mode = DRAW_TRANSLUCENT;
      else                                      rsp_in.draw_mode = DRAW_HIDDEN;
   end

   // per channel animation state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            acc_ff[i]  <= '0;
            pos_ff[i]  <= '0;
            fade_ff[i] <= '0;
         end
      end else begin
         if (cmd.wr_tick) acc_ff[idx]  <= rem[15:0];
         if (cmd.wr_pos)  pos_ff[idx]  <= rem[8:0];
         if (cmd.wr_fade) fade_ff[idx] <= rem[16:0];
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= cmd.rsp_load;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept)   req_ff <= req_data;
      if (cmd.mul_load) begin
         prod_mag_ff <= prod_mag_in;
         prod_neg_ff <= prod_neg_in;
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/sprite_frame_and_fade_animator_unit.sv -----
// ----------------------------------------------------------------------------
// sprite_frame_and_fade_animator_unit
// Four channel sprite animator: frame stepping with optional ping-pong and a
// mirrored alpha fade, configured through a register port.
// ----------------------------------------------------------------------------
//  channel    ports                      handshake
//  request    start, busy, req_data      taken when start is high, busy low
//  response   rsp_strobe, rsp_data       one cycle per query, no stall
//  config     psel/penable/pwrite/...    apb style, 64 bit, no wait states
//
// an advance keeps busy high while, per channel, the shared divider runs for
// the tick sum, for the frame position only when a whole period passed, and
// for the fade counter
// a query keeps busy high through fold and multiply, one divide, response
// reset is synchronous; all channels reset to zero state and default settings
// the response strobe comes in the cycle after the last busy cycle
// ----------------------------------------------------------------------------
module sprite_frame_and_fade_animator_unit
   import sfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   settings_type [NUM_CHAN-1:0] settings_ff;
   logic [CHAN_W-1:0]           csr_idx;
   logic                        csr_write;
   cmd_type                     cmd;
   status_type                  status;

   // register port decode
   assign csr_idx   = paddr[4:3];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = {8'b0, settings_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHAN; i++) settings_ff[i] <= SETTINGS_RESET;
      end else if (csr_write) begin
         settings_ff[csr_idx] <= pwdata[55:0];
      end
   end

   sfa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   sfa_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .settings   (settings_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // a taken request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // responses only leave once the controller is back idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // response strobe is a single cycle pulse
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   // draw mode follows clamped alpha
   a_draw_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.alpha_percent <= FULL_PERCENT) &&
                     ((rsp_data.draw_mode == DRAW_OPAQUE) ==
                      (rsp_data.alpha_percent == FULL_PERCENT)))
      else $error("draw mode does not match alpha");

endmodule

// ----- bench/sprite_frame_and_fade_animator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_frame_and_fade_animator_unit_tb
// Self-checking bench for the four channel sprite animator. A queue-fed
// driver sends advance and query requests, and a monitor keeps a shadow copy
// of the tick, frame and fade state of every channel. From that copy it
// predicts each query response and checks it field by field. The channel
// settings are rewritten over the apb port between phases: directed,
// all zero, all ones and random.
// ----------------------------------------------------------------------------
module sprite_frame_and_fade_animator_unit_tb;
   import sfa_pkg::*;

   localparam int CSR_STRIDE     = 8;      // 56 bit registers on 64 bit slots
   localparam int SETTLE_CYCLES  = 400;    // longer than an advance can stay busy
   localparam int QUIET_LIMIT    = 5000;
   localparam int RAND_PER_PHASE = 165;
   localparam int NUM_PHASES     = 8;

   typedef enum {CFG_DIRECTED, CFG_RANDOM, CFG_ZEROS, CFG_ONES} cfg_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // shadow state of the animator
   settings_type chan_cfg [NUM_CHAN];
   logic [15:0]  acc_ticks [NUM_CHAN];
   logic [8:0]   frame_pos [NUM_CHAN];
   logic [16:0]  fade_step [NUM_CHAN];

   req_type request_q [$];
   rsp_type sprite_expect_q [$];
   int      n_sent = 0;
   int      n_taken = 0;
   int      n_errors = 0;
   int      idle_pct = 0;
   int      quiet_cycles = 0;
   logic    req_taken = 1'b0;

   sprite_frame_and_fade_animator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   // zero frames, period or fade count as one
   function automatic int unsigned eff_frames(settings_type s);
      return (s.frames == 0) ? 1 : s.frames;
   endfunction

   function automatic int unsigned eff_period(settings_type s);
      return (s.period == 0) ? 1 : s.period;
   endfunction

   function automatic int unsigned eff_fade(settings_type s);
      return (s.fade == 0) ? 1 : s.fade;
   endfunction

   // frame cycle length, there and back in ping-pong mode
   function automatic int unsigned loop_len(settings_type s);
      int unsigned n2;
      n2 = 2 * eff_frames(s);
      if (!s.pingpong) return eff_frames(s);
      return (n2 > 2) ? n2 - 2 : 1;
   endfunction

   function automatic void step_channels(logic [15:0] ticks);
      settings_type s;
      int unsigned  per;
      int unsigned  sum;
      int unsigned  fdiv;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         s = chan_cfg[ch];
         per = eff_period(s);
         sum = acc_ticks[ch] + ticks;
         // whole periods move the frame position
         if (sum >= per) begin
            frame_pos[ch] = 9'((frame_pos[ch] + sum / per) % loop_len(s));
            sum = sum % per;
         end
         acc_ticks[ch] = 16'(sum);
         fdiv = eff_fade(s) * (s.mirror ? 2 : 1);
         fade_step[ch] = 17'((fade_step[ch] + 1) % fdiv);
      end
   endfunction

   function automatic rsp_type sprite_view(logic [1:0] ch);
      settings_type s;
      int unsigned  pos;
      int unsigned  cyc;
      longint       st;
      longint       en;
      longint       c;
      longint       dv;
      longint       pct;
      rsp_type      r;
      s = chan_cfg[ch];
      pos = frame_pos[ch];
      // fold back on the return leg, stale positions beyond the cycle show 0
      if (s.pingpong && pos >= eff_frames(s)) begin
         cyc = loop_len(s);
         pos = (pos <= cyc) ? cyc - pos : 0;
      end
      st = s.start_pct;
      en = s.end_pct;
      pct = st;
      if (st != en) begin
         dv = eff_fade(s);
         c = fade_step[ch];
         if (s.mirror && c >= dv) c = 2 * dv - c;
         pct = st + ((en - st) * c) / dv;
      end
      if (pct < 0) pct = 0;
      if (pct > FULL_PERCENT) pct = FULL_PERCENT;
      r.frame_index = pos[7:0];
      r.alpha_percent = pct[6:0];
      if (pct == FULL_PERCENT) r.draw_mode = DRAW_OPAQUE;
      else if (pct > 0) r.draw_mode = DRAW_TRANSLUCENT;
      else r.draw_mode = DRAW_HIDDEN;
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= request_q.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check responses, then predict the request taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_strobe) begin
            if (sprite_expect_q.size() == 0) begin
               $error("response with no query outstanding: %p", rsp_data);
               n_errors++;
            end else begin
               want = sprite_expect_q.pop_front();
               if (rsp_data.frame_index !== want.frame_index) begin
                  $error("frame_index: expected %0d, actual %0d",
                         want.frame_index, rsp_data.frame_index);
                  n_errors++;
               end
               if (rsp_data.alpha_percent !== want.alpha_percent) begin
                  $error("alpha_percent: expected %0d, actual %0d",
                         want.alpha_percent, rsp_data.alpha_percent);
                  n_errors++;
               end
               if (rsp_data.draw_mode !== want.draw_mode) begin
                  $error("draw_mode: expected %0d, actual %0d",
                         want.draw_mode, rsp_data.draw_mode);
                  n_errors++;
               end
            end
         end
         if (start && !busy) begin
            n_taken++;
            if (req_data.op == OP_QUERY) sprite_expect_q.push_back(sprite_view(req_data.channel));
            else step_channels(req_data.elapsed);
         end
      end
   end

   // watchdog on cycles with no request and no response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void send(logic op, logic [15:0] ticks, logic [1:0] ch);
      req_type r;
      r.op = op;
      r.elapsed = ticks;
      r.channel = ch;
      request_q.push_back(r);
      n_sent++;
   endfunction

   function automatic void send_random();
      logic [15:0] ticks;
      case ($urandom_range(3))
         0, 1: ticks = 16'($urandom_range(15));
         2: ticks = 16'($urandom_range(300));
         default: ticks = 16'($urandom);
      endcase
      send(($urandom_range(99) < 40) ? OP_ADVANCE : OP_QUERY, ticks,
           2'($urandom_range(3)));
   endfunction

   // mostly small frame counts, periods and fades so wraps happen often
   function automatic settings_type random_settings();
      logic [63:0]  raw;
      settings_type s;
      raw = {$urandom, $urandom};
      s = raw[55:0];
      if ($urandom_range(3) != 0) s.frames = 8'($urandom_range(9));
      if ($urandom_range(3) != 0) s.period = 16'($urandom_range(40));
      if ($urandom_range(3) != 0) s.fade = 16'($urandom_range(12));
      if ($urandom_range(9) < 7) s.start_pct = 7'($urandom_range(100));
      if ($urandom_range(9) < 7) s.end_pct = 7'($urandom_range(100));
      if ($urandom_range(4) == 0) s.end_pct = s.start_pct;
      return s;
   endfunction

   function automatic settings_type directed_settings(int ch);
      settings_type s;
      s = '0;
      case (ch)
         0: begin
            // ping-pong over four frames, mirrored fade from 0 to 100
            s.frames = 8'd4; s.pingpong = 1'b1; s.period = 16'd3;
            s.start_pct = 7'd0; s.end_pct = 7'd100; s.fade = 16'd5; s.mirror = 1'b1;
         end
         1: begin
            // zero frames, period and fade; equal start and end above 100
            s.start_pct = 7'd127; s.end_pct = 7'd127;
         end
         2: begin
            s.frames = 8'd255; s.period = 16'hFFFF;
            s.start_pct = 7'd100; s.end_pct = 7'd0; s.fade = 16'hFFFF;
         end
         default: begin
            // ping-pong with a single frame, always hidden
            s.frames = 8'd1; s.pingpong = 1'b1; s.period = 16'd1;
            s.fade = 16'd2; s.mirror = 1'b1;
         end
      endcase
      return s;
   endfunction

   // apb write then read back, shadow copy updated at the write edge
   task automatic csr_write(int ch, settings_type val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(CSR_STRIDE * ch);
      pwdata <= {8'h00, val};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      chan_cfg[ch] = val;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[55:0] !== val) begin
         $error("channel%0d_settings: expected %h, actual %h", ch, val, prdata[55:0]);
         n_errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // all requests taken and answered, then let a trailing advance finish
   task automatic wait_drained();
      while (n_taken != n_sent || sprite_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_kind_type plan [NUM_PHASES];
      settings_type s;
      plan = '{CFG_DIRECTED, CFG_RANDOM, CFG_ZEROS, CFG_RANDOM,
               CFG_ONES, CFG_RANDOM, CFG_RANDOM, CFG_RANDOM};
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         chan_cfg[ch] = SETTINGS_RESET;
         acc_ticks[ch] = '0;
         frame_pos[ch] = '0;
         fade_step[ch] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // queries against the reset settings
      idle_pct = 21;
      for (int ch = 0; ch < NUM_CHAN; ch++) send(OP_QUERY, '0, 2'(ch));
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = (p < 3) ? 21 : (p < 6) ? 60 : 0;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            case (plan[p])
               CFG_DIRECTED: s = directed_settings(ch);
               CFG_ZEROS: s = '0;
               CFG_ONES: s = '1;
               default: s = random_settings();
            endcase
            csr_write(ch, s);
         end
         if (plan[p] == CFG_DIRECTED) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) send(OP_QUERY, '0, 2'(ch));
            send(OP_ADVANCE, 16'd0, 2'd0);
            send(OP_QUERY, '0, 2'd0);
            send(OP_QUERY, '0, 2'd3);
            send(OP_ADVANCE, 16'd1, 2'd3);
            send(OP_ADVANCE, 16'd2, 2'd1);
            send(OP_QUERY, '0, 2'd0);
            send(OP_QUERY, '0, 2'd1);
            send(OP_QUERY, '0, 2'd2);
            send(OP_ADVANCE, 16'hFFFF, 2'd2);
            for (int ch = 0; ch < NUM_CHAN; ch++) send(OP_QUERY, 16'hFFFF, 2'(ch));
            send(OP_ADVANCE, 16'd5, 2'd0);
            send(OP_QUERY, '0, 2'd0);
            send(OP_ADVANCE, 16'd5, 2'd0);
            send(OP_QUERY, '0, 2'd0);
         end
         for (int i = 0; i < RAND_PER_PHASE; i++) send_random();
         wait_drained();
      end

      if (n_errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sfa_pkg.sv
rtl/sfa_div.sv
rtl/sfa_ctrl.sv
rtl/sfa_dpath.sv
rtl/sprite_frame_and_fade_animator_unit.sv
bench/sprite_frame_and_fade_animator_unit_tb.sv
